/* hw/rtl/ubx_frame_receiver_top_macros.svh */
// Assertion macros for the frame receiver.
`ifndef UBX_FRAME_RECEIVER_TOP_MACROS_SVH
`define UBX_FRAME_RECEIVER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define UBXFR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`define UBXFR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");

`else

`define UBXFR_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define UBXFR_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/ubxfr_pkg.sv */
package ubxfr_pkg;

    localparam logic [7:0] SYNC_FIRST    = 8'hB5;
    localparam logic [7:0] SYNC_SECOND   = 8'h62;
    localparam logic [7:0] CLS_CFG       = 8'h06;
    localparam logic [7:0] CLS_MON       = 8'h0A;
    localparam logic [7:0] ID_CFG_VALSET = 8'h8A;
    localparam logic [7:0] ID_CFG_PRT    = 8'h00;
    localparam logic [7:0] ID_MON_VER    = 8'h04;

    localparam int unsigned OUT_DATA_W = 64;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_GOOD    = 2'd1,
        EV_BAD     = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        RP_NONE = 2'd0,
        RP_ACK  = 2'd1,
        RP_NAK  = 2'd2
    } t_reply;

    typedef enum logic [8:0] {
        PH_SYNC1   = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_CLASS   = 9'b000000100,
        PH_ID      = 9'b000001000,
        PH_LEN1    = 9'b000010000,
        PH_LEN2    = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CKA     = 9'b010000000,
        PH_CKB     = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic         valid;
        t_event       kind;
        logic [7:0]   pay_byte;
        logic [15:0]  pay_index;
        logic [7:0]   msg_class;
        logic [7:0]   msg_id;
        logic [15:0]  frame_length;
        t_reply       reply;
    } t_result;

    function automatic t_reply reply_for(input logic [7:0] cls, input logic [7:0] id);
        t_reply r;
        r = RP_NONE;
        if (cls == CLS_CFG && id == ID_CFG_VALSET) begin
            r = RP_ACK;
        end else if (cls == CLS_MON && id == ID_MON_VER) begin
            r = RP_ACK;
        end else if (cls == CLS_CFG && id == ID_CFG_PRT) begin
            r = RP_NAK;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/ubxfr_parser.sv */
module ubxfr_parser
    import ubxfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [15:0] r_len, n_len;
    logic [15:0] r_taken, n_taken;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;

    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [15:0] taken_inc;
    logic [15:0] len_full;

    always_comb begin
        add_a     = r_sum_a + i_byte;
        add_b     = r_sum_b + add_a;
        taken_inc = r_taken + 16'd1;
        len_full  = {i_byte, r_len[7:0]};

        n_phase = r_phase;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_len   = r_len;
        n_taken = r_taken;
        n_class = r_class;
        n_id    = r_id;

        o_res              = '0;
        o_res.kind         = EV_PAYLOAD;
        o_res.reply        = RP_NONE;
        o_res.msg_class    = r_class;
        o_res.msg_id       = r_id;
        o_res.frame_length = r_len;

        unique case (r_phase)
            PH_SYNC2: begin
                if (i_byte == SYNC_SECOND) begin
                    n_phase = PH_CLASS;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_CLASS: begin
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_class = i_byte;
                n_phase = PH_ID;
            end
            PH_ID: begin
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_id    = i_byte;
                n_phase = PH_LEN1;
            end
            PH_LEN1: begin
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_len   = {8'd0, i_byte};
                n_phase = PH_LEN2;
            end
            PH_LEN2: begin
                n_sum_a = add_a;
                n_sum_b = add_b;
                n_len   = len_full;
                n_phase = (len_full != 16'd0) ? PH_PAYLOAD : PH_CKA;
            end
            PH_PAYLOAD: begin
                n_sum_a         = add_a;
                n_sum_b         = add_b;
                o_res.valid     = 1'b1;
                o_res.kind      = EV_PAYLOAD;
                o_res.pay_byte  = i_byte;
                o_res.pay_index = r_taken;
                n_taken         = taken_inc;
                if (taken_inc >= r_len) begin
                    n_phase = PH_CKA;
                end
            end
            PH_CKA: begin
                if (i_byte != r_sum_a) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = EV_BAD;
                    n_phase     = PH_SYNC1;
                    n_sum_a     = '0;
                    n_sum_b     = '0;
                    n_len       = '0;
                    n_taken     = '0;
                end else begin
                    n_phase = PH_CKB;
                end
            end
            PH_CKB: begin
                o_res.valid = 1'b1;
                if (i_byte != r_sum_b) begin
                    o_res.kind = EV_BAD;
                end else begin
                    o_res.kind  = EV_GOOD;
                    o_res.reply = reply_for(r_class, r_id);
                end
                n_phase = PH_SYNC1;
                n_sum_a = '0;
                n_sum_b = '0;
                n_len   = '0;
                n_taken = '0;
            end
            default: begin
                n_phase = (i_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
                n_sum_a = '0;
                n_sum_b = '0;
                n_len   = '0;
                n_taken = '0;
            end
        endcase

        o_res.valid = o_res.valid & i_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_len   <= '0;
            r_taken <= '0;
            r_class <= '0;
            r_id    <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_len   <= n_len;
            r_taken <= n_taken;
            r_class <= n_class;
            r_id    <= n_id;
        end
    end

endmodule

/* hw/rtl/ubx_frame_receiver_top.sv */
// A result is registered and reaches the master side in the cycle after its byte transfer.
// Throughput: one byte per cycle unless stalled; the result register frees in the cycle
// it is taken. The byte side stalls only while a result is held and i_m_tready is low.
// Reset (i_rst_n low at a clock edge, synchronous) empties the result register,
// returns the parser to the first sync byte and clears sums, length, count, class and id.
`include "ubx_frame_receiver_top_macros.svh"

module ubx_frame_receiver_top
    import ubxfr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] rx_byte
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [7:0] payload_byte, [23:8] payload_index,
                                               // [31:24] msg_class, [39:32] msg_id,
                                               // [55:40] frame_length, [57:56] reply_kind
    output logic [1:0]            o_m_tuser    // [1:0] event_kind
);

    t_result res;
    logic    s_xfer;
    logic    r_valid;
    t_result r_res;

    assign o_s_tready = !r_valid || i_m_tready;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    ubxfr_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_xfer),
        .i_byte  (i_s_tdata),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_xfer) begin
            r_valid <= res.valid;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer && res.valid) begin
            r_res <= res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_res.kind;
    assign o_m_tdata  = {6'd0, r_res.reply, r_res.frame_length, r_res.msg_id,
                         r_res.msg_class, r_res.pay_index, r_res.pay_byte};

    `UBXFR_ASSERT_IMP(a_kind_legal, i_clk, i_rst_n, o_m_tvalid, o_m_tuser != 2'd3)
    `UBXFR_ASSERT_IMP(a_reply_good_only, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != EV_GOOD, o_m_tdata[57:56] == RP_NONE)
    `UBXFR_ASSERT_IMP(a_index_in_len, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == EV_PAYLOAD, o_m_tdata[23:8] < o_m_tdata[55:40])
    `UBXFR_ASSERT_NXT(a_result_follows, i_clk, i_rst_n, s_xfer && res.valid, o_m_tvalid)

endmodule
